// ===== hw/rtl/psnap_pkg.sv =====
package psnap_pkg;

	localparam int SNAP_BITS = 16;
	localparam int D2_BITS   = 2 * SNAP_BITS;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_START = 2'd1,
		KIND_END   = 2'd2,
		KIND_FOOT  = 2'd3
	} snap_kind_t;

	// per-transaction control that rides alongside the datapath
	typedef struct packed {
		logic       valid;
		snap_kind_t kind;
		logic       try_foot;
	} psnap_ctl_t;

endpackage

// ===== hw/rtl/psnap_in_if.sv =====
interface psnap_in_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] seg_start_x;
	logic signed [COORD_BITS-1:0] seg_start_y;
	logic signed [COORD_BITS-1:0] seg_end_x;
	logic signed [COORD_BITS-1:0] seg_end_y;

	modport source (output valid, point_x, point_y, seg_start_x, seg_start_y,
		seg_end_x, seg_end_y, input ready);
	modport sink (input valid, point_x, point_y, seg_start_x, seg_start_y,
		seg_end_x, seg_end_y, output ready);
endinterface

// ===== hw/rtl/psnap_cfg_if.sv =====
interface psnap_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [psnap_pkg::SNAP_BITS-1:0]    snap_distance;

	modport source (output valid, snap_distance, input ready);
	modport sink (input valid, snap_distance, output ready);
endinterface

// ===== hw/rtl/psnap_out_if.sv =====
interface psnap_out_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic                         attached;
	logic [1:0]                   snap_kind;
	logic signed [COORD_BITS-1:0] snap_x;
	logic signed [COORD_BITS-1:0] snap_y;

	modport source (output valid, attached, snap_kind, snap_x, snap_y, input ready);
	modport sink (input valid, attached, snap_kind, snap_x, snap_y, output ready);
endinterface

// ===== hw/rtl/psnap_front.sv =====
// Geometry front end: endpoint tests, line equation, foot numerators.
module psnap_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic signed [COORD_BITS-1:0]    px,
	input  logic signed [COORD_BITS-1:0]    py,
	input  logic signed [COORD_BITS-1:0]    x1,
	input  logic signed [COORD_BITS-1:0]    y1,
	input  logic signed [COORD_BITS-1:0]    x2,
	input  logic signed [COORD_BITS-1:0]    y2,
	input  logic [psnap_pkg::SNAP_BITS-1:0] snap,
	output psnap_pkg::psnap_ctl_t           ctl,
	output logic [3*COORD_BITS+4:0]         mag_x,
	output logic [3*COORD_BITS+4:0]         mag_y,
	output logic                            neg_x,
	output logic                            neg_y,
	output logic [2*COORD_BITS:0]           dd,
	output logic [4*COORD_BITS-1:0]         box
);
	localparam int W   = COORD_BITS;
	localparam int DW  = W + 1;
	localparam int CW1 = 2 * W + 1;
	localparam int SW  = 2 * W + 2;
	localparam int DLW = 2 * W + 3;
	localparam int DDW = 2 * W + 1;
	localparam int NW  = 3 * W + 5;
	localparam int D2W = psnap_pkg::D2_BITS;
	localparam int EW  = (SW > D2W) ? SW : D2W;
	localparam int CMW = (2 * DLW > DDW + D2W) ? 2 * DLW : DDW + D2W;

	// stage 1
	logic                  v_s1;
	logic signed [W-1:0]   px_s1, py_s1;
	logic signed [DW-1:0]  dx0_s1, dy0_s1, dx1_s1, dy1_s1, a_s1, b_s1;
	logic signed [2*W-1:0] c1_s1, c2_s1;
	logic [D2W-1:0]        d2_s1;
	logic [4*W-1:0]        box_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= px;
			py_s1  <= py;
			dx0_s1 <= DW'(px) - DW'(x1);
			dy0_s1 <= DW'(py) - DW'(y1);
			dx1_s1 <= DW'(px) - DW'(x2);
			dy1_s1 <= DW'(py) - DW'(y2);
			a_s1   <= DW'(y1) - DW'(y2);
			b_s1   <= DW'(x2) - DW'(x1);
			c1_s1  <= y2 * x1;
			c2_s1  <= y1 * x2;
			d2_s1  <= snap * snap;
			box_s1 <= {x1, y1, x2, y2};
		end
	end

	// stage 2: squares and line products
	logic signed [SW-1:0]  sq_dx0, sq_dy0, sq_dx1, sq_dy1, sq_a, sq_b;
	logic signed [CW1-1:0] pa_c, pb_c;

	assign sq_dx0 = dx0_s1 * dx0_s1;
	assign sq_dy0 = dy0_s1 * dy0_s1;
	assign sq_dx1 = dx1_s1 * dx1_s1;
	assign sq_dy1 = dy1_s1 * dy1_s1;
	assign sq_a   = a_s1 * a_s1;
	assign sq_b   = b_s1 * b_s1;
	assign pa_c   = a_s1 * px_s1;
	assign pb_c   = b_s1 * py_s1;

	logic                  v_s2;
	logic [SW-1:0]         dist0_s2, dist1_s2;
	logic signed [CW1-1:0] c_s2, pa_s2, pb_s2;
	logic [DDW-1:0]        dd_s2;
	logic signed [DW-1:0]  a_s2, b_s2;
	logic signed [W-1:0]   px_s2, py_s2;
	logic [D2W-1:0]        d2_s2;
	logic [4*W-1:0]        box_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			dist0_s2 <= $unsigned(sq_dx0) + $unsigned(sq_dy0);
			dist1_s2 <= $unsigned(sq_dx1) + $unsigned(sq_dy1);
			c_s2     <= CW1'(c1_s1) - CW1'(c2_s1);
			pa_s2    <= pa_c;
			pb_s2    <= pb_c;
			dd_s2    <= DDW'($unsigned(sq_a)) + DDW'($unsigned(sq_b));
			a_s2     <= a_s1;
			b_s2     <= b_s1;
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			d2_s2    <= d2_s1;
			box_s2   <= box_s1;
		end
	end

	// stage 3: delta and endpoint decision
	logic hit0, hit1;
	assign hit0 = (dist0_s2 != '0) && (EW'(dist0_s2) < EW'(d2_s2));
	assign hit1 = (dist1_s2 != '0) && (EW'(dist1_s2) < EW'(d2_s2));

	logic                   v_s3;
	logic signed [DLW-1:0]  delta_s3;
	psnap_pkg::snap_kind_t  kind_s3;
	logic [DDW-1:0]         dd_s3;
	logic signed [DW-1:0]   a_s3, b_s3;
	logic signed [W-1:0]    px_s3, py_s3;
	logic [D2W-1:0]         d2_s3;
	logic [4*W-1:0]         box_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			delta_s3 <= DLW'(pa_s2) + DLW'(pb_s2) + DLW'(c_s2);
			kind_s3  <= hit0 ? psnap_pkg::KIND_START :
				hit1 ? psnap_pkg::KIND_END : psnap_pkg::KIND_NONE;
			dd_s3    <= dd_s2;
			a_s3     <= a_s2;
			b_s3     <= b_s2;
			px_s3    <= px_s2;
			py_s3    <= py_s2;
			d2_s3    <= d2_s2;
			box_s3   <= box_s2;
		end
	end

	// stage 4: products for the distance test and the foot numerators
	logic [DLW-1:0]           dm;
	logic [2*DLW-1:0]         dsq_c;
	logic [DDW+D2W-1:0]       lim_c;
	logic signed [DW+DLW-1:0] ad_c, bd_c;
	logic signed [W+DDW:0]    xdd_c, ydd_c;

	assign dm    = delta_s3[DLW-1] ? $unsigned(-delta_s3) : $unsigned(delta_s3);
	assign dsq_c = dm * dm;
	assign lim_c = dd_s3 * d2_s3;
	assign ad_c  = a_s3 * delta_s3;
	assign bd_c  = b_s3 * delta_s3;
	assign xdd_c = px_s3 * $signed({1'b0, dd_s3});
	assign ydd_c = py_s3 * $signed({1'b0, dd_s3});

	logic                     v_s4, nz_s4;
	logic [2*DLW-1:0]         dsq_s4;
	logic [DDW+D2W-1:0]       lim_s4;
	logic signed [DW+DLW-1:0] ad_s4, bd_s4;
	logic signed [W+DDW:0]    xdd_s4, ydd_s4;
	psnap_pkg::snap_kind_t    kind_s4;
	logic [DDW-1:0]           dd_s4;
	logic [4*W-1:0]           box_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			nz_s4   <= (delta_s3 != '0) && (dd_s3 != '0);
			dsq_s4  <= dsq_c;
			lim_s4  <= lim_c;
			ad_s4   <= ad_c;
			bd_s4   <= bd_c;
			xdd_s4  <= xdd_c;
			ydd_s4  <= ydd_c;
			kind_s4 <= kind_s3;
			dd_s4   <= dd_s3;
			box_s4  <= box_s3;
		end
	end

	// stage 5: foot gate and numerators
	logic                  v_s5, try_s5;
	logic signed [NW-1:0]  nx_s5, ny_s5;
	psnap_pkg::snap_kind_t kind_s5;
	logic [DDW-1:0]        dd_s5;
	logic [4*W-1:0]        box_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			try_s5  <= (kind_s4 == psnap_pkg::KIND_NONE) && nz_s4 &&
				(CMW'(dsq_s4) < CMW'(lim_s4));
			nx_s5   <= NW'(xdd_s4) - NW'(ad_s4);
			ny_s5   <= NW'(ydd_s4) - NW'(bd_s4);
			kind_s5 <= kind_s4;
			dd_s5   <= dd_s4;
			box_s5  <= box_s4;
		end
	end

	// stage 6: sign and magnitude for the divider
	logic                  v_s6, try_s6;
	psnap_pkg::snap_kind_t kind_s6;
	logic [NW-1:0]         mag_x_s6, mag_y_s6;
	logic                  neg_x_s6, neg_y_s6;
	logic [DDW-1:0]        dd_s6;
	logic [4*W-1:0]        box_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_x_s6 <= nx_s5[NW-1];
			neg_y_s6 <= ny_s5[NW-1];
			mag_x_s6 <= nx_s5[NW-1] ? $unsigned(-nx_s5) : $unsigned(nx_s5);
			mag_y_s6 <= ny_s5[NW-1] ? $unsigned(-ny_s5) : $unsigned(ny_s5);
			kind_s6  <= kind_s5;
			try_s6   <= try_s5;
			dd_s6    <= dd_s5;
			box_s6   <= box_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign ctl   = psnap_pkg::psnap_ctl_t'{valid: v_s6, kind: kind_s6, try_foot: try_s6};
	assign mag_x = mag_x_s6;
	assign mag_y = mag_y_s6;
	assign neg_x = neg_x_s6;
	assign neg_y = neg_y_s6;
	assign dd    = dd_s6;
	assign box   = box_s6;

endmodule

// ===== hw/rtl/psnap_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Range check first: quotient >= 2^(W+1) flags ovf, then W+1 steps.
module psnap_div #(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [3*COORD_BITS+4:0] mag,
	input  logic                    neg,
	input  logic [2*COORD_BITS:0]   dd,
	output logic [COORD_BITS:0]     quo,
	output logic [2*COORD_BITS:0]   rem,
	output logic [2*COORD_BITS:0]   dd_o,
	output logic                    neg_o,
	output logic                    ovf_o
);
	localparam int W   = COORD_BITS;
	localparam int NW  = 3 * W + 5;
	localparam int DDW = 2 * W + 1;
	localparam int HW  = NW - W - 1;

	logic [W:0]     low_s [0:W+1];
	logic [DDW-1:0] rem_s [0:W+1];
	logic [DDW-1:0] dd_s  [0:W+1];
	logic [W:0]     quo_s [0:W+1];
	logic           neg_s [0:W+1];
	logic           ovf_s [0:W+1];

	logic [HW-1:0] hi;
	assign hi = mag[NW-1:W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= hi >= HW'(dd);
			rem_s[0] <= hi[DDW-1:0];
			low_s[0] <= mag[W:0];
			quo_s[0] <= '0;
			dd_s[0]  <= dd;
			neg_s[0] <= neg;
		end
	end

	for (genvar k = 0; k <= W; k++) begin : g_step
		logic [DDW:0] rs, diff;
		logic         ge;

		assign rs   = {rem_s[k], low_s[k][W-k]};
		assign diff = rs - {1'b0, dd_s[k]};
		assign ge   = rs >= {1'b0, dd_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[DDW-1:0] : rs[DDW-1:0];
				quo_s[k+1] <= {quo_s[k][W-1:0], ge};
				low_s[k+1] <= low_s[k];
				dd_s[k+1]  <= dd_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign quo   = quo_s[W+1];
	assign rem   = rem_s[W+1];
	assign dd_o  = dd_s[W+1];
	assign neg_o = neg_s[W+1];
	assign ovf_o = ovf_s[W+1];

endmodule

// ===== hw/rtl/point_segment_snap.sv =====
// Channel  | Dir | Handshake     | Payload
// ---------+-----+---------------+-----------------------------------------------
// in_ch    | in  | valid / ready | point_x/y, seg_start_x/y, seg_end_x/y
// cfg      | in  | valid / ready | snap_distance (ready is always high)
// out_ch   | out | valid / ready | attached, snap_kind, snap_x, snap_y
//
// One transaction per cycle while out_ch is not stalled; the quotient pipeline
// (one bit per stage) sits behind six geometry stages.
// arst_n clears every valid bit and snap_distance; datapath registers are not reset.
// A stall on out_ch freezes the whole pipe in place; in_ch.ready drops with it.
module point_segment_snap #(
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	psnap_in_if.sink    in_ch,
	psnap_cfg_if.sink   cfg,
	psnap_out_if.source out_ch
);
	localparam int W   = COORD_BITS;
	localparam int NW  = 3 * W + 5;
	localparam int DDW = 2 * W + 1;
	localparam int QW  = W + 2;

	// snap radius register
	logic [psnap_pkg::SNAP_BITS-1:0] snap_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_q <= '0;
		end else if (cfg.valid) begin
			snap_q <= cfg.snap_distance;
		end
	end

	// global advance: the pipe moves whenever the output slot is free or taken
	logic out_v_q;
	logic adv;

	assign adv         = !out_v_q || out_ch.ready;
	assign in_ch.ready = adv;

	// geometry stages
	psnap_pkg::psnap_ctl_t ctl_f;
	logic [NW-1:0]         mag_x, mag_y;
	logic                  neg_x, neg_y;
	logic [DDW-1:0]        dd_f;
	logic [4*W-1:0]        box_f;

	psnap_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (in_ch.valid),
		.px       (in_ch.point_x),
		.py       (in_ch.point_y),
		.x1       (in_ch.seg_start_x),
		.y1       (in_ch.seg_start_y),
		.x2       (in_ch.seg_end_x),
		.y2       (in_ch.seg_end_y),
		.snap     (snap_q),
		.ctl      (ctl_f),
		.mag_x    (mag_x),
		.mag_y    (mag_y),
		.neg_x    (neg_x),
		.neg_y    (neg_y),
		.dd       (dd_f),
		.box      (box_f)
	);

	// one divider lane per coordinate
	logic [W:0]     quo_x, quo_y;
	logic [DDW-1:0] rem_x, rem_y, dd_x, dd_y;
	logic           dneg_x, dneg_y, ovf_x, ovf_y;

	psnap_div #(.COORD_BITS(COORD_BITS)) u_div_x (
		.clk   (clk),
		.en    (adv),
		.mag   (mag_x),
		.neg   (neg_x),
		.dd    (dd_f),
		.quo   (quo_x),
		.rem   (rem_x),
		.dd_o  (dd_x),
		.neg_o (dneg_x),
		.ovf_o (ovf_x)
	);

	psnap_div #(.COORD_BITS(COORD_BITS)) u_div_y (
		.clk   (clk),
		.en    (adv),
		.mag   (mag_y),
		.neg   (neg_y),
		.dd    (dd_f),
		.quo   (quo_y),
		.rem   (rem_y),
		.dd_o  (dd_y),
		.neg_o (dneg_y),
		.ovf_o (ovf_y)
	);

	// control and bounding box ride along the divider depth
	psnap_pkg::psnap_ctl_t ctl_div_s [0:W+1];
	logic [4*W-1:0]        box_div_s [0:W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_div_s[0] <= '0;
		end else if (adv) begin
			ctl_div_s[0] <= ctl_f;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			box_div_s[0] <= box_f;
		end
	end

	for (genvar k = 1; k <= W + 1; k++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_div_s[k] <= '0;
			end else if (adv) begin
				ctl_div_s[k] <= ctl_div_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				box_div_s[k] <= box_div_s[k-1];
			end
		end
	end

	// rounding stage: half up on magnitude (ties away from zero), then sign
	logic          up_x, up_y, fail_x, fail_y;
	logic [QW-1:0] qr_x, qr_y;

	assign up_x   = {rem_x, 1'b0} >= {1'b0, dd_x};
	assign up_y   = {rem_y, 1'b0} >= {1'b0, dd_y};
	assign qr_x   = QW'(quo_x) + QW'(up_x);
	assign qr_y   = QW'(quo_y) + QW'(up_y);
	assign fail_x = ovf_x || (qr_x > (QW'(1) << W));
	assign fail_y = ovf_y || (qr_y > (QW'(1) << W));

	psnap_pkg::psnap_ctl_t ctl_sr;
	logic signed [QW-1:0]  fx_sr, fy_sr;
	logic                  fail_sr;
	logic [4*W-1:0]        box_sr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sr <= '0;
		end else if (adv) begin
			ctl_sr <= ctl_div_s[W+1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_sr   <= dneg_x ? $signed(-qr_x) : $signed(qr_x);
			fy_sr   <= dneg_y ? $signed(-qr_y) : $signed(qr_y);
			fail_sr <= fail_x || fail_y;
			box_sr  <= box_div_s[W+1];
		end
	end

	// output stage: bounding box test (inclusive) and result select
	logic signed [W-1:0] bx1, by1, bx2, by2;
	logic signed [QW-1:0] ex1, ey1, ex2, ey2;
	logic                 in_x, in_y, foot_ok;

	assign bx1 = $signed(box_sr[4*W-1:3*W]);
	assign by1 = $signed(box_sr[3*W-1:2*W]);
	assign bx2 = $signed(box_sr[2*W-1:W]);
	assign by2 = $signed(box_sr[W-1:0]);
	assign ex1 = QW'(bx1);
	assign ey1 = QW'(by1);
	assign ex2 = QW'(bx2);
	assign ey2 = QW'(by2);

	assign in_x = (ex1 < ex2) ? (fx_sr >= ex1 && fx_sr <= ex2) : (fx_sr >= ex2 && fx_sr <= ex1);
	assign in_y = (ey1 < ey2) ? (fy_sr >= ey1 && fy_sr <= ey2) : (fy_sr >= ey2 && fy_sr <= ey1);
	assign foot_ok = ctl_sr.try_foot && !fail_sr && in_x && in_y;

	logic                  attached_q;
	psnap_pkg::snap_kind_t kind_q;
	logic signed [W-1:0]   sx_q, sy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= ctl_sr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (ctl_sr.kind)
				psnap_pkg::KIND_START: begin
					attached_q <= 1'b1;
					kind_q     <= psnap_pkg::KIND_START;
					sx_q       <= bx1;
					sy_q       <= by1;
				end
				psnap_pkg::KIND_END: begin
					attached_q <= 1'b1;
					kind_q     <= psnap_pkg::KIND_END;
					sx_q       <= bx2;
					sy_q       <= by2;
				end
				default: begin
					attached_q <= foot_ok;
					kind_q     <= foot_ok ? psnap_pkg::KIND_FOOT : psnap_pkg::KIND_NONE;
					sx_q       <= foot_ok ? fx_sr[W-1:0] : '0;
					sy_q       <= foot_ok ? fy_sr[W-1:0] : '0;
				end
			endcase
		end
	end

	assign out_ch.valid     = out_v_q;
	assign out_ch.attached  = attached_q;
	assign out_ch.snap_kind = kind_q;
	assign out_ch.snap_x    = sx_q;
	assign out_ch.snap_y    = sy_q;

endmodule
